>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define SGCT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be true at a clock edge out of reset.
`define SGCT_NEVER(name, cond, msg) \
  `SGCT_ASSERT(name, !(cond), msg)

`endif

>>> rtl/sgct_pkg.sv
// ---------------------------------------------------------------------------
// sgct_pkg
// Types, constants and the control store of the scaled game clock tick
// generator.
// ---------------------------------------------------------------------------
package sgct_pkg;

  // shared shift/subtract divider
  localparam int DivW        = 32;
  localparam int NumW        = 65;   // 64-bit advance plus carried remainder
  localparam int CntW        = 7;
  localparam int ScaleBits   = 10;   // quotient bits of the ms fraction
  localparam int TickDivBits = 11;   // tick-split dividend stays below 2000

  // tick split: floor(x / tick) as (x * ceil(2^22 / tick)) >> 22, exact for x < 2048
  localparam int TickRecipShift = 22;

  localparam logic [31:0] MinFreq      = 32'd1001;
  localparam logic [31:0] FreqReset    = 32'd10000000;
  localparam logic [31:0] StartMsReset = 32'd0;
  localparam logic [31:0] MsPerSec     = 32'd1000;
  localparam logic [31:0] GapLimitMs   = 32'd1000;
  localparam logic [22:0] MaxWholeSec  = 23'd4294967;

  // ceil(x / 1000) as ((x + 999) >> 3) * ceil(2^37 / 125) >> 37
  localparam logic [9:0]  RoundUp1000  = 10'd999;
  localparam logic [30:0] Recip125     = 31'd1099511628;
  localparam int          RecipShift   = 37;

  localparam logic [1:0] SLOW_FULL    = 2'd0;
  localparam logic [1:0] SLOW_HALF    = 2'd1;
  localparam logic [1:0] SLOW_QUARTER = 2'd2;

  typedef enum logic [1:0] {
    REG_FREQ,
    REG_PAUSE,
    REG_SLOWMO,
    REG_START_MS
  } reg_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DELTA,
    OP_ADDREM,
    OP_DIV,
    OP_SCALE,
    OP_MS,
    OP_RECIP,
    OP_SPLIT,
    OP_TQUOT,
    OP_TICK,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_WAIT_IN,
    JC_UNPRIMED,
    JC_LOOP,
    JC_EMIT
  } jcond_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_ADDREM,
    ST_DIV1,
    ST_SCALE,
    ST_DIV2,
    ST_MS,
    ST_RECIP,
    ST_SPLIT,
    ST_TQUOT,
    ST_TICK,
    ST_EMIT
  } step_e;

  typedef struct packed {
    op_e    op;
    jcond_e jcond;
    step_e  target;
  } uword_t;

  typedef struct packed {
    logic            load;
    logic            step;
    logic [DivW-1:0] divisor;
    logic [DivW-1:0] rem_init;
    logic [NumW-1:0] num_init;
    logic [CntW-1:0] count;
  } div_cmd_t;

  function automatic uword_t ucode_rom(input step_e step);
    uword_t uw;
    uw = '{OP_IDLE, JC_WAIT_IN, ST_IDLE};
    unique case (step)
      ST_IDLE:   uw = '{OP_IDLE,   JC_WAIT_IN,  ST_IDLE};
      ST_DELTA:  uw = '{OP_DELTA,  JC_UNPRIMED, ST_SPLIT};
      ST_ADDREM: uw = '{OP_ADDREM, JC_NEXT,     ST_IDLE};
      ST_DIV1:   uw = '{OP_DIV,    JC_LOOP,     ST_IDLE};
      ST_SCALE:  uw = '{OP_SCALE,  JC_NEXT,     ST_IDLE};
      ST_DIV2:   uw = '{OP_DIV,    JC_LOOP,     ST_IDLE};
      ST_MS:     uw = '{OP_MS,     JC_NEXT,     ST_IDLE};
      ST_RECIP:  uw = '{OP_RECIP,  JC_NEXT,     ST_IDLE};
      ST_SPLIT:  uw = '{OP_SPLIT,  JC_NEXT,     ST_IDLE};
      ST_TQUOT:  uw = '{OP_TQUOT,  JC_NEXT,     ST_IDLE};
      ST_TICK:   uw = '{OP_TICK,   JC_NEXT,     ST_IDLE};
      ST_EMIT:   uw = '{OP_EMIT,   JC_EMIT,     ST_IDLE};
      default:   uw = '{OP_IDLE,   JC_WAIT_IN,  ST_IDLE};
    endcase
    return uw;
  endfunction

endpackage

>>> rtl/sgct_div.sv
// ---------------------------------------------------------------------------
// sgct_div
// Restoring shift/subtract divider, one quotient bit per cycle. Quotient
// bits shift into the low end of the numerator register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sgct_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sgct_pkg::div_cmd_t                  cmd_i,
  output logic [sgct_pkg::DivW-1:0]           rem_o,
  output logic [sgct_pkg::NumW-1:0]           num_o,
  output logic                                last_o
);
  import sgct_pkg::*;

  logic [DivW-1:0] div_q;
  logic [DivW-1:0] rem_q, rem_d;
  logic [NumW-1:0] num_q, num_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW:0]   trial;
  logic            fits;

  always_comb begin
    trial = {rem_q, num_q[NumW-1]};
    fits  = (trial >= {1'b0, div_q});
    rem_d = rem_q;
    num_d = num_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      rem_d = cmd_i.rem_init;
      num_d = cmd_i.num_init;
      cnt_d = cmd_i.count;
    end else if (cmd_i.step) begin
      rem_d = fits ? DivW'(trial - {1'b0, div_q}) : trial[DivW-1:0];
      num_d = {num_q[NumW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      div_q <= cmd_i.divisor;
    end
    rem_q <= rem_d;
    num_q <= num_d;
  end

  assign rem_o  = rem_q;
  assign num_o  = num_q;
  assign last_o = (cnt_q == CntW'(1));

  `SGCT_NEVER(a_step_exhausted, cmd_i.step && (cnt_q == '0), "divider stepped past its count")
  `SGCT_NEVER(a_load_and_step, cmd_i.load && cmd_i.step, "divider load and step together")

endmodule

>>> rtl/scaled_game_clock_tick_generator.sv
// ---------------------------------------------------------------------------
// Scaled game clock tick generator
// Accepted samples pass the shared one-bit-per-cycle divider twice (65-bit
// advance, then 10-bit fraction); the priming sample skips both. A new sample
// waits until the last is emitted; reset spares the working and result data.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module scaled_game_clock_tick_generator #(
  parameter int GAME_TICK_MS = 50,
  parameter int TIME_WIDTH   = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] counter_sample_i,
  input  logic        step_request_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] elapsed_ms_o,
  output logic [47:0] running_time_o,
  output logic [47:0] paused_time_o,
  output logic [31:0] millisecond_count_o,
  output logic [7:0]  game_ticks_due_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sgct_pkg::*;

  localparam int TW       = TIME_WIDTH;
  localparam int TickRemW = $clog2(GAME_TICK_MS + 1);
  localparam logic [TW-1:0] TickT = TW'(GAME_TICK_MS);
  localparam logic [TickDivBits-1:0] TickLen = TickDivBits'(GAME_TICK_MS);
  localparam logic [22:0] TickRecip =
    23'((2**TickRecipShift + GAME_TICK_MS - 1) / GAME_TICK_MS);

  // sequencer
  step_e  pc_q, pc_d;
  uword_t uw;

  // config registers
  logic [31:0] freq_q, freq_d;
  logic        pause_q, pause_d;
  logic [1:0]  slowmo_q, slowmo_d;
  logic [31:0] start_ms_q, start_ms_d;

  // architectural state
  logic [63:0]         prev_q, prev_d;
  logic [32:0]         tr_q, tr_d;
  logic                primed_q, primed_d;
  logic                step_pend_q, step_pend_d;
  logic [TW-1:0]       running_q, running_d;
  logic [TW-1:0]       pause_clk_q, pause_clk_d;
  logic [31:0]         ms_cnt_q, ms_cnt_d;
  logic [TW-1:0]       rt_q, rt_d;             // running clock in whole ticks
  logic [TickRemW-1:0] rm_q, rm_d;             // running clock mod tick
  logic [TW-1:0]       last_tick_q, last_tick_d;

  // per-transaction working registers
  logic [63:0] sample_q, sample_d;
  logic [63:0] delta_q, delta_d;
  logic        meas_q, meas_d;
  logic [22:0] q_q, q_d;
  logic        qsat_q, qsat_d;
  logic [31:0] e_q, e_d;
  logic [30:0] y_q, y_d;
  logic [61:0] prod_q, prod_d;
  logic [TickDivBits-1:0] tn_q, tn_d;          // rm + run_add, split into ticks
  logic [TickDivBits-1:0] tq_q, tq_d;          // whole ticks in tn

  // result register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_e_q, out_e_d;
  logic [47:0] out_run_q, out_run_d;
  logic [47:0] out_pause_q, out_pause_d;
  logic [31:0] out_ms_q, out_ms_d;
  logic [7:0]  out_frames_q, out_frames_d;

  // divider
  div_cmd_t        div_cmd;
  logic [DivW-1:0] div_rem;
  logic [NumW-1:0] div_num;
  logic            div_last;

  logic        accept;
  logic        out_free;
  logic        cfg_wr;
  logic [31:0] f_eff;
  logic [64:0] delta_diff;
  logic [41:0] scale_prod;
  logic [33:0] ms_full;
  logic [TW:0] tick_diff;
  logic [33:0] tick_prod;

  // time split
  logic [TW-1:0]          e_w;
  logic [TW-1:0]          run_add;
  logic [TW-1:0]          pause_add;
  logic                   step_clr;
  logic [TW:0]            run_sum;
  logic [TickDivBits-1:0] tick_num;

  sgct_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .rem_o  (div_rem),
    .num_o  (div_num),
    .last_o (div_last)
  );

  assign uw         = ucode_rom(pc_q);
  assign in_stall_o = (pc_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cfg_wr     = psel && penable && pwrite;
  assign f_eff      = (freq_q < MinFreq) ? MinFreq : freq_q;
  assign delta_diff = {1'b0, sample_q} - {1'b0, prev_q};
  assign scale_prod = 42'(div_rem) * 42'(MsPerSec);
  assign ms_full    = 34'(q_q) * 34'(MsPerSec) + 34'(div_num[ScaleBits-1:0]);
  assign tick_diff  = {1'b0, rt_q} - {1'b0, last_tick_q};
  assign tick_prod  = 34'(tn_q) * 34'(TickRecip);
  assign e_w        = TW'(e_q);

  // split of measured milliseconds between running and pause clocks
  always_comb begin
    run_add   = '0;
    pause_add = '0;
    step_clr  = 1'b0;
    if (meas_q) begin
      if (pause_q) begin
        if (step_pend_q) begin
          run_add   = TickT;
          pause_add = e_w - TickT;
          step_clr  = 1'b1;
        end else begin
          pause_add = e_w;
        end
      end else if (e_q > GapLimitMs) begin
        run_add   = TickT;
        pause_add = e_w - TickT;
      end else begin
        case (slowmo_q)
          SLOW_FULL: run_add = e_w;
          SLOW_HALF: run_add = e_w >> 1;
          default:   run_add = e_w >> 2;
        endcase
        pause_add = e_w - run_add;
      end
    end
    run_sum = {1'b0, running_q} + {1'b0, run_add};
    // on wrap the new clock is below the added amount, so its tick restarts at 0
    if (run_sum[TW]) begin
      tick_num = TickDivBits'(run_sum[TW-1:0]);
    end else begin
      tick_num = TickDivBits'(rm_q) + TickDivBits'(run_add);
    end
  end

  always_comb begin
    pc_d         = pc_q;
    freq_d       = freq_q;
    pause_d      = pause_q;
    slowmo_d     = slowmo_q;
    start_ms_d   = start_ms_q;
    prev_d       = prev_q;
    tr_d         = tr_q;
    primed_d     = primed_q;
    step_pend_d  = step_pend_q;
    running_d    = running_q;
    pause_clk_d  = pause_clk_q;
    ms_cnt_d     = ms_cnt_q;
    rt_d         = rt_q;
    rm_d         = rm_q;
    last_tick_d  = last_tick_q;
    sample_d     = sample_q;
    delta_d      = delta_q;
    meas_d       = meas_q;
    q_d          = q_q;
    qsat_d       = qsat_q;
    e_d          = e_q;
    y_d          = y_q;
    prod_d       = prod_q;
    tn_d         = tn_q;
    tq_d         = tq_q;
    out_valid_d  = out_valid_q;
    out_e_d      = out_e_q;
    out_run_d    = out_run_q;
    out_pause_d  = out_pause_q;
    out_ms_d     = out_ms_q;
    out_frames_d = out_frames_q;
    div_cmd      = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (uw.op)
      OP_IDLE: begin
        if (accept) begin
          sample_d = counter_sample_i;
          if (pause_q && step_request_i) begin
            step_pend_d = 1'b1;
          end
        end
      end
      OP_DELTA: begin
        if (!primed_q) begin
          prev_d   = sample_q;
          primed_d = 1'b1;
          meas_d   = 1'b0;
          e_d      = '0;
        end else begin
          meas_d = 1'b1;
          // a backwards sample counts as no advance and keeps the old sample
          if (!delta_diff[64]) begin
            delta_d = delta_diff[63:0];
            prev_d  = sample_q;
          end else begin
            delta_d = '0;
          end
        end
      end
      OP_ADDREM: begin
        div_cmd.load     = 1'b1;
        div_cmd.divisor  = f_eff;
        div_cmd.rem_init = '0;
        div_cmd.num_init = {1'b0, delta_q} + NumW'(tr_q);
        div_cmd.count    = CntW'(NumW);
      end
      OP_DIV: begin
        div_cmd.step = 1'b1;
      end
      OP_SCALE: begin
        q_d    = div_num[22:0];
        qsat_d = (|div_num[NumW-1:23]) || (div_num[22:0] > MaxWholeSec);
        // fraction: (r * 1000) / f, quotient below 1000, so start pre-shifted
        div_cmd.load     = 1'b1;
        div_cmd.divisor  = f_eff;
        div_cmd.rem_init = scale_prod[41:ScaleBits];
        div_cmd.num_init = {scale_prod[ScaleBits-1:0], {(NumW - ScaleBits){1'b0}}};
        div_cmd.count    = CntW'(ScaleBits);
      end
      OP_MS: begin
        if (qsat_q || (|ms_full[33:32])) begin
          e_d = '1;
        end else begin
          e_d = ms_full[31:0];
        end
        // new carry is ceil(frac_rem / 1000)
        y_d = 31'((33'(div_rem) + 33'(RoundUp1000)) >> 3);
      end
      OP_RECIP: begin
        prod_d = 62'(y_q) * 62'(Recip125);
      end
      OP_SPLIT: begin
        if (meas_q) begin
          tr_d     = 33'(prod_q >> RecipShift);
          ms_cnt_d = ms_cnt_q + e_q;
        end
        if (step_clr) begin
          step_pend_d = 1'b0;
        end
        running_d   = run_sum[TW-1:0];
        pause_clk_d = pause_clk_q + pause_add;
        if (run_sum[TW]) begin
          rt_d = '0;
        end
        tn_d = tick_num;
      end
      OP_TQUOT: begin
        tq_d = tick_prod[TickRecipShift +: TickDivBits];
      end
      OP_TICK: begin
        rt_d = rt_q + TW'(tq_q);
        rm_d = TickRemW'(tn_q - tq_q * TickLen);
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_e_d      = e_q;
          out_run_d    = 48'(running_q);
          out_pause_d  = 48'(pause_clk_q);
          out_ms_d     = ms_cnt_q;
          out_frames_d = '0;
          if (!tick_diff[TW]) begin
            out_frames_d = (|tick_diff[TW-1:8]) ? 8'hFF : tick_diff[7:0];
            if (tick_diff != '0) begin
              last_tick_d = rt_q;
            end
          end
        end
      end
      default: ;
    endcase

    if (cfg_wr) begin
      unique case (reg_e'(paddr[3:2]))
        REG_FREQ:   freq_d = pwdata;
        REG_PAUSE: begin
          pause_d = pwdata[0];
          if (!pwdata[0]) begin
            step_pend_d = 1'b0;
          end
        end
        REG_SLOWMO:   slowmo_d   = pwdata[1:0];
        REG_START_MS: start_ms_d = pwdata;
        default: ;
      endcase
    end

    unique case (uw.jcond)
      JC_NEXT:     pc_d = step_e'(4'(pc_q) + 4'd1);
      JC_WAIT_IN:  pc_d = accept ? step_e'(4'(pc_q) + 4'd1) : pc_q;
      JC_UNPRIMED: pc_d = !primed_q ? uw.target : step_e'(4'(pc_q) + 4'd1);
      JC_LOOP:     pc_d = div_last ? step_e'(4'(pc_q) + 4'd1) : pc_q;
      JC_EMIT:     pc_d = out_free ? uw.target : pc_q;
      default:     pc_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ST_IDLE;
      freq_q      <= FreqReset;
      pause_q     <= 1'b0;
      slowmo_q    <= SLOW_FULL;
      start_ms_q  <= StartMsReset;
      prev_q      <= '0;
      tr_q        <= '0;
      primed_q    <= 1'b0;
      step_pend_q <= 1'b0;
      running_q   <= '0;
      pause_clk_q <= '0;
      ms_cnt_q    <= StartMsReset;
      rt_q        <= '0;
      rm_q        <= '0;
      last_tick_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      freq_q      <= freq_d;
      pause_q     <= pause_d;
      slowmo_q    <= slowmo_d;
      start_ms_q  <= start_ms_d;
      prev_q      <= prev_d;
      tr_q        <= tr_d;
      primed_q    <= primed_d;
      step_pend_q <= step_pend_d;
      running_q   <= running_d;
      pause_clk_q <= pause_clk_d;
      ms_cnt_q    <= ms_cnt_d;
      rt_q        <= rt_d;
      rm_q        <= rm_d;
      last_tick_q <= last_tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q     <= sample_d;
    delta_q      <= delta_d;
    meas_q       <= meas_d;
    q_q          <= q_d;
    qsat_q       <= qsat_d;
    e_q          <= e_d;
    y_q          <= y_d;
    prod_q       <= prod_d;
    tn_q         <= tn_d;
    tq_q         <= tq_d;
    out_e_q      <= out_e_d;
    out_run_q    <= out_run_d;
    out_pause_q  <= out_pause_d;
    out_ms_q     <= out_ms_d;
    out_frames_q <= out_frames_d;
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_FREQ:     prdata = freq_q;
      REG_PAUSE:    prdata = 32'(pause_q);
      REG_SLOWMO:   prdata = 32'(slowmo_q);
      REG_START_MS: prdata = start_ms_q;
      default:      prdata = '0;
    endcase
  end

  assign pready              = 1'b1;
  assign out_valid_o         = out_valid_q;
  assign elapsed_ms_o        = out_e_q;
  assign running_time_o      = out_run_q;
  assign paused_time_o       = out_pause_q;
  assign millisecond_count_o = out_ms_q;
  assign game_ticks_due_o    = out_frames_q;

  `SGCT_ASSERT(a_result_from_emit, $rose(out_valid_o) |-> $past(pc_q == ST_EMIT), "result raised outside emit step")
  `SGCT_ASSERT(a_frac_start_bound, (pc_q == ST_DIV2) && $past(pc_q == ST_SCALE) |-> (div_rem < f_eff), "fraction divide starts with remainder not below divisor")
  `SGCT_NEVER(a_tick_rem_range, 32'(rm_q) >= 32'(GAME_TICK_MS), "tick remainder not below tick length")
  `SGCT_NEVER(a_carry_bound, |tr_q[32:23], "carried counter remainder out of range")

endmodule
